FILE: sv/ssf_pkg.sv
// Shared types and constants for the SWD sequence framer.
`timescale 1ns / 1ps

package ssf_pkg;

  // Operation codes
  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_WRITE_PAR = 2'd1;
  localparam logic [1:0] OP_READ      = 2'd2;
  localparam logic [1:0] OP_READ_PAR  = 2'd3;

  // Header flag positions
  localparam int unsigned WRITE_FLAG_BIT = 6;
  localparam int unsigned MODE_FLAG_BIT  = 7;

  // Field widths and limits
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PAYLOAD_W = 40;
  localparam logic [5:0]  MAX_BITS  = 6'd32;

  // One framed result word
  typedef struct packed {
    logic [7:0]           header_byte;
    logic [PAYLOAD_W-1:0] send_payload;
    logic [2:0]           byte_count;
    logic [DATA_W-1:0]    read_data;
    logic                 parity_ok;
    logic                 length_error;
  } ssf_result_t;

endpackage

FILE: sv/swd_sequence_spi_framer_core.sv
// Top level: input register, framing logic and result register.
// An accepted word is held in the input register, framed, and then loaded into the result register.
// Throughput: one word per cycle unless the output stalls; the framing is one pass of
// shifts, masks and a 32-bit parity tree between the input register and the result register.
// Reset clears both valid flags and sets the line-direction bit to driven.
`timescale 1ns / 1ps

module swd_sequence_spi_framer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic [5:0]                    bit_count_i,
  input  logic [ssf_pkg::DATA_W-1:0]    write_data_i,
  input  logic [ssf_pkg::PAYLOAD_W-1:0] read_payload_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    header_byte_o,
  output logic [ssf_pkg::PAYLOAD_W-1:0] send_payload_o,
  output logic [2:0]                    byte_count_o,
  output logic [ssf_pkg::DATA_W-1:0]    read_data_o,
  output logic                          parity_ok_o,
  output logic                          length_error_o
);
  import ssf_pkg::*;

  logic                 in_valid_q, in_valid_d;
  logic [1:0]           op_q;
  logic [5:0]           cnt_q;
  logic [DATA_W-1:0]    wdata_q;
  logic [PAYLOAD_W-1:0] rpay_q;
  logic                 out_valid_q, out_valid_d;
  ssf_result_t          res_q, res_d;
  logic                 line_driven_q, line_driven_d, line_next;
  logic                 out_load;
  logic                 in_acc;

  // Handshake: advance the input word when the result register frees up
  assign out_load    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !out_load;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_acc || (in_valid_q && !out_load);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  ssf_frame_calc u_calc (
    .operation_i    (op_q),
    .bit_count_i    (cnt_q),
    .write_data_i   (wdata_q),
    .read_payload_i (rpay_q),
    .line_driven_i  (line_driven_q),
    .result_o       (res_d),
    .line_driven_o  (line_next)
  );

  assign line_driven_d = out_load ? line_next : line_driven_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      line_driven_q <= 1'b1;
    end else begin
      in_valid_q    <= in_valid_d;
      out_valid_q   <= out_valid_d;
      line_driven_q <= line_driven_d;
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= operation_i;
      cnt_q   <= bit_count_i;
      wdata_q <= write_data_i;
      rpay_q  <= read_payload_i;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign header_byte_o  = res_q.header_byte;
  assign send_payload_o = res_q.send_payload;
  assign byte_count_o   = res_q.byte_count;
  assign read_data_o    = res_q.read_data;
  assign parity_ok_o    = res_q.parity_ok;
  assign length_error_o = res_q.length_error;

endmodule

FILE: sv/ssf_frame_calc.sv
// Combinational framing of one request: header, send bits, read decode.
`timescale 1ns / 1ps

module ssf_frame_calc (
  input  logic [1:0]                    operation_i,
  input  logic [5:0]                    bit_count_i,
  input  logic [ssf_pkg::DATA_W-1:0]    write_data_i,
  input  logic [ssf_pkg::PAYLOAD_W-1:0] read_payload_i,
  input  logic                          line_driven_i,
  output ssf_pkg::ssf_result_t          result_o,
  output logic                          line_driven_o
);
  import ssf_pkg::*;

  logic                 is_write;
  logic                 with_par;
  logic                 bad_len;
  logic                 trn;
  logic [5:0]           len;
  logic [5:0]           len_m1;
  logic [5:0]           par_pos;
  logic [7:0]           hdr;
  logic [DATA_W-1:0]    mask;
  logic [DATA_W-1:0]    wdata_m;
  logic [DATA_W-1:0]    wdata_rev;
  logic [PAYLOAD_W-1:0] send_bits;
  logic [PAYLOAD_W-1:0] par_bit;
  logic [PAYLOAD_W-1:0] rx_aligned;
  logic [DATA_W-1:0]    rx_rev;
  logic [DATA_W-1:0]    rdata;
  logic                 rx_par;
  logic [6:0]           bytes_raw;

  // Decode the operation and length
  assign is_write = (operation_i == OP_WRITE) || (operation_i == OP_WRITE_PAR);
  assign with_par = (operation_i == OP_WRITE_PAR) || (operation_i == OP_READ_PAR);
  assign bad_len  = (bit_count_i == 6'd0) || (bit_count_i > MAX_BITS);

  // Turnaround goes in front when the direction flips
  assign trn     = is_write ? ~line_driven_i : line_driven_i;
  assign len     = bit_count_i + {5'd0, trn} + {5'd0, with_par};
  assign len_m1  = len - 6'd1;
  assign par_pos = bit_count_i + {5'd0, trn};

  // Build the header byte: length minus one, write flag for writes, mode flag clear
  always_comb begin
    hdr = {2'b00, len_m1};
    if (is_write) begin
      hdr[WRITE_FLAG_BIT] = 1'b1;
    end
    hdr[MODE_FLAG_BIT] = 1'b0;
  end

  // Mask data to the bit count (valid for counts 1..32)
  assign mask    = {DATA_W{1'b1}} >> (MAX_BITS - bit_count_i);
  assign wdata_m = write_data_i & mask;

  // Reverse data and received bits: first bit on the wire sits at the top
  assign rx_aligned = read_payload_i << trn;
  always_comb begin
    for (int b = 0; b < DATA_W; b++) begin
      wdata_rev[DATA_W-1-b] = wdata_m[b];
      rx_rev[b]             = rx_aligned[PAYLOAD_W-1-b];
    end
  end

  // Place the send bits and the optional parity bit
  assign send_bits = {wdata_rev, 8'h00} >> trn;
  assign par_bit   = (with_par && (^wdata_m)) ?
                     ({1'b1, {(PAYLOAD_W-1){1'b0}}} >> par_pos) : '0;

  // Decode the read data and check its parity
  assign rdata     = rx_rev & mask;
  assign rx_par    = rx_aligned[6'd39 - bit_count_i];
  assign bytes_raw = ({1'b0, len} + 7'd7) >> 3;

  // Assemble the result word
  always_comb begin
    result_o = '0;
    if (bad_len) begin
      result_o.length_error = 1'b1;
    end else begin
      result_o.header_byte = hdr;
      result_o.byte_count  = bytes_raw[2:0] + 3'd1;
      if (is_write) begin
        result_o.send_payload = send_bits | par_bit;
      end else begin
        result_o.read_data = rdata;
        result_o.parity_ok = with_par && (rx_par == (^rdata));
      end
    end
  end

  // Writes leave the line driven, reads leave it floating; a length error keeps it as it was
  assign line_driven_o = bad_len ? line_driven_i : is_write;

endmodule

FILE: sv/ssf_checker.sv
// Port-level checks for the SWD sequence framer, bound to the top level.
`timescale 1ns / 1ps

module ssf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [7:0]                    header_byte_o,
  input logic [ssf_pkg::PAYLOAD_W-1:0] send_payload_o,
  input logic [2:0]                    byte_count_o,
  input logic [ssf_pkg::DATA_W-1:0]    read_data_o,
  input logic                          parity_ok_o,
  input logic                          length_error_o
);
  import ssf_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(header_byte_o) &&
    $stable(send_payload_o) && $stable(read_data_o) && $stable(byte_count_o))
    else $error("stalled result word changed");

  // Drop everything on a length error
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_error_o |-> byte_count_o == 3'd0 &&
    header_byte_o == 8'd0 && send_payload_o == '0 && read_data_o == '0 &&
    !parity_ok_o)
    else $error("error word carries data");

  // A good frame holds the header and at least one payload byte, with the mode flag clear
  a_bytes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !length_error_o |-> byte_count_o >= 3'd2 && byte_count_o <= 3'd6 &&
    !header_byte_o[MODE_FLAG_BIT])
    else $error("byte count or mode flag out of range");

  // Writes decode no read data and flag no read parity
  a_dir_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !length_error_o && header_byte_o[WRITE_FLAG_BIT] |->
    read_data_o == '0 && !parity_ok_o)
    else $error("write word carries read fields");

endmodule

bind swd_sequence_spi_framer_core ssf_checker u_ssf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .header_byte_o  (header_byte_o),
  .send_payload_o (send_payload_o),
  .byte_count_o   (byte_count_o),
  .read_data_o    (read_data_o),
  .parity_ok_o    (parity_ok_o),
  .length_error_o (length_error_o)
);
